[design/lbi_pkg.sv]
// Shared types, constants and color scaling functions for the LED blade ignite effect.
package lbi_pkg;

    localparam int MAX_LEDS    = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_IGNITING   = 2'd1,
        MODE_STEADY     = 2'd2,
        MODE_RETRACTING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_IGNITE  = 2'd1,
        OP_RETRACT = 2'd2,
        OP_RENDER  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_BLADE_COLOR      = 3'd0,
        REG_LED_COUNT        = 3'd1,
        REG_IGNITE_DURATION  = 3'd2,
        REG_RETRACT_DURATION = 3'd3,
        REG_TIP_DIM_LEVEL    = 3'd4,
        REG_PULSE_PERIOD     = 3'd5,
        REG_PULSE_LOW        = 3'd6,
        REG_PULSE_HIGH       = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PROG_WAIT,
        B_PHASE_WAIT,
        B_PULSE_MUL,
        B_PULSE_WAIT,
        B_PIX_START,
        B_GRAD_WAIT,
        B_SCALE1,
        B_SCALE2
    } back_state_t;

    // Effective configuration, with out-of-range values already folded.
    typedef struct packed {
        logic [23:0] color;
        logic [6:0]  len;
        logic [15:0] ign_dur;
        logic [15:0] ret_dur;
        logic [7:0]  tip;
        logic [15:0] period;
        logic [7:0]  plo;
        logic [7:0]  phi;
    } cfg_t;

    typedef struct packed {
        op_t         kind;
        logic [15:0] delta;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
        logic [5:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [15:0] rem;
    } div_rsp_t;

    // c * f / 255 rounded down; exact for every product below 65536.
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] f);
        logic [15:0] x;
        logic [16:0] y;
        x = c * f;
        y = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return y[15:8];
    endfunction

    function automatic logic [23:0] scale_rgb(input logic [23:0] rgb, input logic [7:0] f);
        return {scale8(rgb[23:16], f), scale8(rgb[15:8], f), scale8(rgb[7:0], f)};
    endfunction

endpackage

[design/lbi_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module lbi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lbi_pkg::div_req_t req,
    output lbi_pkg::div_rsp_t rsp
);
    import lbi_pkg::*;

    logic [31:0] num_reg, num_next;
    logic [31:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic        ge;

    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[31]};
        ge        = trial >= {1'b0, den_reg};
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            cnt_next  = req.steps;
            rem_next  = '0;
            quot_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            quot_next = {quot_reg[30:0], ge};
            num_next  = {num_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule

[design/lbi_front.sv]
// Input side: accepts words, classifies the operation and queues them for the back end.
module lbi_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     operation,
    input  logic [15:0]    elapsed_ms,
    output logic           q_valid,
    output lbi_pkg::item_t q_item,
    input  logic           q_pop
);
    import lbi_pkg::*;

    item_t       mem_reg [QUEUE_DEPTH];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       item_in;

    assign in_stall = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        item_in.kind  = op_t'(operation);
        item_in.delta = elapsed_ms;
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = q_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= item_in;
        end
    end
endmodule

[design/lbi_back.sv]
// Execution side: mode and timer state, frame setup and the per-LED color sequencer.
module lbi_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lbi_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  lbi_pkg::item_t      q_item,
    output logic                q_pop,
    output lbi_pkg::div_req_t   dreq,
    input  lbi_pkg::div_rsp_t   drsp,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          pixel_index,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [1:0]          blade_mode,
    output logic                last
);
    import lbi_pkg::*;

    back_state_t state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [16:0] sweep_reg, sweep_next;
    logic [31:0] steady_reg, steady_next;
    logic [6:0]  n_reg, n_next;
    logic [6:0]  lit_reg, lit_next;
    logic [7:0]  frac_reg, frac_next;
    logic [7:0]  pulse_reg, pulse_next;
    logic [23:0] num_reg, num_next;
    logic        up_reg, up_next;
    logic [6:0]  idx_reg, idx_next;
    logic [7:0]  gq_reg, gq_next;
    logic [23:0] rgb_reg, rgb_next;
    logic        ov_reg, ov_next;
    logic [5:0]  opix_reg, opix_next;
    logic [23:0] ocol_reg, ocol_next;
    logic [1:0]  omode_reg, omode_next;
    logic        olast_reg, olast_next;

    logic [15:0] dur;
    logic [17:0] sum;
    logic [14:0] x;
    logic [14:0] gnum;
    logic [14:0] half;
    logic [7:0]  range;
    logic [15:0] phase;
    logic [23:0] pcol;
    logic        is_last;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        sweep_next  = sweep_reg;
        steady_next = steady_reg;
        n_next      = n_reg;
        lit_next    = lit_reg;
        frac_next   = frac_reg;
        pulse_next  = pulse_reg;
        num_next    = num_reg;
        up_next     = up_reg;
        idx_next    = idx_reg;
        gq_next     = gq_reg;
        rgb_next    = rgb_reg;
        ov_next     = ov_reg && out_stall;
        opix_next   = opix_reg;
        ocol_next   = ocol_reg;
        omode_next  = omode_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        dreq        = '0;
        dur   = (mode_reg == MODE_IGNITING) ? cfg.ign_dur : cfg.ret_dur;
        sum   = {1'b0, sweep_reg} + {2'b0, q_item.delta};
        x     = '0;
        half  = cfg.period[15:1];
        range = cfg.phi - cfg.plo;
        phase = drsp.rem;
        gnum  = 15'((8'd255 - cfg.tip) * idx_reg);
        pcol  = '0;
        is_last = (idx_reg == n_reg - 7'd1);

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        OP_TICK:
                        begin
                            if (mode_reg == MODE_IGNITING || mode_reg == MODE_RETRACTING)
                            begin
                                if (sum >= {2'b0, dur})
                                begin
                                    sweep_next = '0;
                                    if (mode_reg == MODE_IGNITING)
                                    begin
                                        steady_next = '0;
                                        mode_next   = MODE_STEADY;
                                    end
                                    else
                                    begin
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                else
                                begin
                                    sweep_next = sum[16:0];
                                end
                            end
                            else if (mode_reg == MODE_STEADY)
                            begin
                                steady_next = steady_reg + {16'd0, q_item.delta};
                            end
                        end
                        OP_IGNITE:
                        begin
                            sweep_next  = '0;
                            steady_next = '0;
                            mode_next   = MODE_IGNITING;
                        end
                        OP_RETRACT:
                        begin
                            sweep_next = '0;
                            mode_next  = MODE_RETRACTING;
                        end
                        OP_RENDER:
                        begin
                            n_next   = cfg.len;
                            idx_next = '0;
                            state_next = B_PIX_START;
                            if (mode_reg == MODE_IGNITING || mode_reg == MODE_RETRACTING)
                            begin
                                if (sweep_reg >= {1'b0, dur})
                                begin
                                    // Sweep at or past its end: progress is full.
                                    lit_next  = (mode_reg == MODE_IGNITING) ? cfg.len : 7'd0;
                                    frac_next = '0;
                                end
                                else
                                begin
                                    dreq.start = 1'b1;
                                    dreq.num   = {sweep_reg[15:0], 16'd0};
                                    dreq.den   = dur;
                                    dreq.steps = 6'd24;
                                    state_next = B_PROG_WAIT;
                                end
                            end
                            else if (mode_reg == MODE_STEADY)
                            begin
                                dreq.start = 1'b1;
                                dreq.num   = steady_reg;
                                dreq.den   = cfg.period;
                                dreq.steps = 6'd32;
                                state_next = B_PHASE_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_PROG_WAIT:
            begin
                if (drsp.done)
                begin
                    x = 15'(drsp.quot[7:0] * n_reg);
                    frac_next = x[7:0];
                    lit_next  = (mode_reg == MODE_IGNITING) ? x[14:8] : n_reg - x[14:8];
                    state_next = B_PIX_START;
                end
            end
            B_PHASE_WAIT:
            begin
                if (drsp.done)
                begin
                    if (phase < {1'b0, half})
                    begin
                        num_next = range * phase;
                        up_next  = 1'b1;
                    end
                    else
                    begin
                        num_next = range * (phase - {1'b0, half});
                        up_next  = 1'b0;
                    end
                    state_next = B_PULSE_MUL;
                end
            end
            B_PULSE_MUL:
            begin
                dreq.start = 1'b1;
                dreq.num   = {num_reg, 8'd0};
                dreq.den   = {1'b0, half};
                dreq.steps = 6'd24;
                state_next = B_PULSE_WAIT;
            end
            B_PULSE_WAIT:
            begin
                if (drsp.done)
                begin
                    pulse_next = up_reg ? cfg.plo + drsp.quot[7:0] : cfg.phi - drsp.quot[7:0];
                    state_next = B_PIX_START;
                end
            end
            B_PIX_START:
            begin
                if (n_reg > 7'd1)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = {gnum[13:0], 18'd0};
                    dreq.den   = {9'd0, n_reg - 7'd1};
                    dreq.steps = 6'd14;
                    state_next = B_GRAD_WAIT;
                end
                else
                begin
                    gq_next    = '0;
                    state_next = B_SCALE1;
                end
            end
            B_GRAD_WAIT:
            begin
                if (drsp.done)
                begin
                    gq_next    = drsp.quot[7:0];
                    state_next = B_SCALE1;
                end
            end
            B_SCALE1:
            begin
                rgb_next   = scale_rgb(cfg.color, 8'd255 - gq_reg);
                state_next = B_SCALE2;
            end
            B_SCALE2:
            begin
                unique case (mode_reg)
                    MODE_IGNITING:
                    begin
                        if (idx_reg < lit_reg)
                            pcol = rgb_reg;
                        else if (idx_reg == lit_reg && frac_reg != 8'd0)
                            pcol = scale_rgb(rgb_reg, frac_reg);
                    end
                    MODE_RETRACTING:
                    begin
                        if (idx_reg < lit_reg)
                        begin
                            pcol = rgb_reg;
                            if (idx_reg == lit_reg - 7'd1 && frac_reg != 8'd0)
                                pcol = scale_rgb(rgb_reg, 8'd255 - frac_reg);
                        end
                    end
                    MODE_STEADY:
                    begin
                        pcol = rgb_reg;
                        if (idx_reg == 7'd0 || is_last)
                            pcol = scale_rgb(rgb_reg, pulse_reg);
                    end
                    default: pcol = '0;
                endcase
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    opix_next  = idx_reg[5:0];
                    ocol_next  = pcol;
                    omode_next = mode_reg;
                    olast_next = is_last;
                    idx_next   = idx_reg + 7'd1;
                    state_next = is_last ? B_IDLE : B_PIX_START;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            mode_reg   <= MODE_IDLE;
            sweep_reg  <= '0;
            steady_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            sweep_reg  <= sweep_next;
            steady_reg <= steady_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        lit_reg   <= lit_next;
        frac_reg  <= frac_next;
        pulse_reg <= pulse_next;
        num_reg   <= num_next;
        up_reg    <= up_next;
        idx_reg   <= idx_next;
        gq_reg    <= gq_next;
        rgb_reg   <= rgb_next;
        opix_reg  <= opix_next;
        ocol_reg  <= ocol_next;
        omode_reg <= omode_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ov_reg;
    assign pixel_index = opix_reg;
    assign red         = ocol_reg[23:16];
    assign green       = ocol_reg[15:8];
    assign blue        = ocol_reg[7:0];
    assign blade_mode  = omode_reg;
    assign last        = olast_reg;
endmodule

[design/led_blade_ignite_effect.sv]
// Top level of the LED blade ignite effect: configuration registers, front end, back end, divider.
//
// Usage. Command words enter on the input channel (in_valid, in_stall, operation,
// elapsed_ms): tick, ignite, retract or render. A render produces one word per LED
// on the output channel (out_valid, out_stall, pixel_index, colors, blade_mode,
// last), base LED first, with last set on the tip LED. Ticks, ignites and
// retracts produce no output words.
// Operation. The front end takes a word whenever its two-entry queue
// has room, so words are taken while a render is still running. The back end runs
// one word at a time. A render first sets up the frame (a 32-step period
// remainder and a 24-step pulse division in steady mode, a 24-step progress
// division while sweeping) and then emits the LEDs one by one, each after a
// 14-step gradient division in the shared serial divider when the strip has
// more than one LED.
// Reset clears the mode to idle and both timers, and loads the register defaults.
// When the receiver stalls, the output word holds and the LED sequencer waits;
// the queue then fills and in_stall rises. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while idle (the block does not enforce it).
module led_blade_ignite_effect (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [1:0]  blade_mode,
    output logic        last
);
    import lbi_pkg::*;

    logic [23:0] color_reg;
    logic [6:0]  count_reg;
    logic [15:0] ign_reg;
    logic [15:0] ret_reg;
    logic [7:0]  tip_reg;
    logic [15:0] period_reg;
    logic [7:0]  plo_reg;
    logic [7:0]  phi_reg;

    cfg_t     cfg;
    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    div_req_t dreq;
    div_rsp_t drsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg  <= 24'h0000FF;
            count_reg  <= 7'd64;
            ign_reg    <= 16'd1000;
            ret_reg    <= 16'd500;
            tip_reg    <= 8'd64;
            period_reg <= 16'd1000;
            plo_reg    <= 8'd128;
            phi_reg    <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BLADE_COLOR:      color_reg  <= cfg_data;
                REG_LED_COUNT:        count_reg  <= cfg_data[6:0];
                REG_IGNITE_DURATION:  ign_reg    <= cfg_data[15:0];
                REG_RETRACT_DURATION: ret_reg    <= cfg_data[15:0];
                REG_TIP_DIM_LEVEL:    tip_reg    <= cfg_data[7:0];
                REG_PULSE_PERIOD:     period_reg <= cfg_data[15:0];
                REG_PULSE_LOW:        plo_reg    <= cfg_data[7:0];
                REG_PULSE_HIGH:       phi_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Fold the out-of-range register values: a zero LED count or duration acts
    // as one, a count above the strip maximum is clipped, and the pulse period
    // is at least two.
    always_comb
    begin
        cfg.color   = color_reg;
        cfg.len     = (count_reg == 7'd0) ? 7'd1 :
                      (count_reg > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : count_reg;
        cfg.ign_dur = (ign_reg == 16'd0) ? 16'd1 : ign_reg;
        cfg.ret_dur = (ret_reg == 16'd0) ? 16'd1 : ret_reg;
        cfg.tip     = tip_reg;
        cfg.period  = (period_reg < 16'd2) ? 16'd2 : period_reg;
        cfg.plo     = plo_reg;
        cfg.phi     = phi_reg;
    end

    lbi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .elapsed_ms (elapsed_ms),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    lbi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    lbi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .dreq        (dreq),
        .drsp        (drsp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .blade_mode  (blade_mode),
        .last        (last)
    );
endmodule
